### sv/lcbe_pkg.sv
// ----------------------------------------------------------------------------
// lcbe_pkg: shared types and constants for the LRU key directory
// Holds the table geometry, the command and result codes, the payload
// structs, the sequencer state type and the age-order function.
// ----------------------------------------------------------------------------
package lcbe_pkg;

  localparam int ENTRIES    = 16;
  localparam int STAMP_BITS = 16;
  localparam int SLOT_W     = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int KEY_W      = 31;
  localparam int CFG_W      = 5;
  localparam int REC_W      = 1 + KEY_W + STAMP_BITS;

  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  typedef enum logic [1:0] {
    CMD_FETCH  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_TRIM   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_EVICT  = 3'd0,
    KIND_HIT    = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_MISS   = 3'd3,
    KIND_BYPASS = 3'd4,
    KIND_DONE   = 3'd5
  } kind_t;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_OVER = 1'b1;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
    logic             source_has_row;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [KEY_W-1:0] result_key;
    logic [3:0]       slot;
    logic [4:0]       occupancy;
    logic             last;
  } out_item_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic                  valid;
    logic [KEY_W-1:0]      key;
    logic [STAMP_BITS-1:0] stamp;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,      // walk the table: find key, oldest entry, first free slot
    ST_SCAN_END,  // last read lands
    ST_DECIDE,
    ST_EVICT,     // invalidate the oldest entry, emit it
    ST_RN_OUTER,  // renumber: pick entry i
    ST_RN_INNER,  // renumber: count entries older than i
    ST_RN_WRITE,
    ST_WRITE,     // final write of hit / insert / remove
    ST_CLEAR,
    ST_EMIT       // final result waits for the output register
  } state_t;

  // Strict age order: smaller stamp first, lower slot on a tie.
  function automatic logic is_older(input logic [STAMP_BITS-1:0] sa,
                                    input logic [SLOT_W-1:0] ia,
                                    input logic [STAMP_BITS-1:0] sb,
                                    input logic [SLOT_W-1:0] ib);
    is_older = (sa < sb) || ((sa == sb) && (ia < ib));
  endfunction

endpackage

### sv/lru_cache_batch_eviction.sv
// ----------------------------------------------------------------------------
// lru_cache_batch_eviction: LRU key directory with batch eviction
// Fully associative table of keys with access stamps kept in one RAM.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Direction | Payload
//  --------+--------------------------------+-----------+-------------------
//  in      | in_valid, in_stall, in_data    | input     | command,key,row
//  out     | out_valid, out_stall, out_data | output    | kind,key,slot,...
//  cfg     | cfg_we, cfg_index, cfg_data    | input     | base, overflow
//
// One item at a time: no new item is accepted until the current one has
// passed its last result to the output register. Every item begins with a
// scan of the table through the single RAM read port. Each eviction adds
// another scan plus a write; a stamp renumbering runs a ranking pass that
// holds the new stamps in registers, then a read-modify-write pass that
// stores them.
// Reset clears the valid flags with a sweep over all ENTRIES slots, during
// which no transfer is accepted on the input channel.
// A stall on the output holds the sequencer at the next result.
//
module lru_cache_batch_eviction
  import lcbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]      base_r, over_r;
  in_item_t              item_r;
  logic [STAMP_BITS-1:0] ctr_r, ctr_nxt;
  logic [KEY_W:0]        prev_r;         // top bit set means no previous key
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      todo_r, todo_nxt; // evictions still to do
  logic                  insert_r, insert_nxt;

  // Scan bookkeeping.
  logic [SLOT_W:0]       addr_r, addr_nxt;  // read address (extra bit: done)
  logic [SLOT_W-1:0]     rslot_r;           // slot of the data on the read port
  logic                  found_r;
  logic [SLOT_W-1:0]     found_slot_r;
  logic                  old_ok_r;
  logic [SLOT_W-1:0]     old_slot_r;
  logic [STAMP_BITS-1:0] old_stamp_r;
  logic [KEY_W-1:0]      old_key_r;
  logic                  free_ok_r;
  logic [SLOT_W-1:0]     free_slot_r;
  logic                  scan_rd;           // read data on the port is live

  // Renumbering bookkeeping. The ranking pass compares old stamps only, so
  // the new stamps wait in rank_r until the second (commit) pass.
  logic [SLOT_W:0]       rn_i_r;
  rec_t                  rn_rec_r;
  logic [STAMP_BITS-1:0] rn_rank_r;
  logic [STAMP_BITS-1:0] rn_live_r;
  logic                  rn_commit_r;
  logic [CNT_W-1:0]      rank_r [ENTRIES];

  logic                  clr_done_r;
  logic [SLOT_W-1:0]     clr_addr_r;

  // RAM port.
  logic                  we;
  logic [SLOT_W-1:0]     waddr, raddr;
  rec_t                  wrec, rrec;

  out_item_t             res;
  logic                  res_go;
  logic                  out_free;

  logic [CNT_W:0]        cap_sum;
  logic [CNT_W-1:0]      cap;
  logic [CNT_W-1:0]      base_c;
  logic                  new_key;

  lcbe_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wrec),
    .raddr(raddr),
    .rdata(rrec)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !clr_done_r;

  // Capacity is base plus overflow, clamped to the table size.
  assign cap_sum = {{(CNT_W+1-CFG_W){1'b0}}, base_r} + {{(CNT_W+1-CFG_W){1'b0}}, over_r};
  assign cap     = (cap_sum > (CNT_W+1)'(ENTRIES)) ? CNT_W'(ENTRIES) : cap_sum[CNT_W-1:0];
  assign base_c  = ({{(CNT_W+1-CFG_W){1'b0}}, base_r} < {1'b0, cap}) ?
                   base_r[CNT_W-1:0] : cap;
  assign new_key = prev_r != {1'b0, item_r.key};

  assign raddr   = (state_r == ST_RN_OUTER || state_r == ST_RN_WRITE) ?
                   rn_i_r[SLOT_W-1:0] : addr_r[SLOT_W-1:0];
  assign scan_rd = (state_r == ST_SCAN && addr_r != '0) || state_r == ST_SCAN_END;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && clr_done_r) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_r == (SLOT_W+1)'(ENTRIES - 1)) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        case (item_r.command)
          CMD_CLEAR:  state_nxt = ST_CLEAR;
          CMD_REMOVE: state_nxt = ST_WRITE;
          CMD_TRIM:   state_nxt = (todo_nxt != '0 && old_ok_r) ? ST_EVICT : ST_EMIT;
          default: begin
            if (cap == '0) state_nxt = ST_EMIT;
            else if (new_key && ctr_r == STAMP_MAX) state_nxt = ST_RN_OUTER;
            else if (found_r || !item_r.source_has_row) state_nxt = ST_WRITE;
            else if (todo_nxt != '0 && old_ok_r) state_nxt = ST_EVICT;
            else state_nxt = ST_WRITE;
          end
        endcase
      end
      ST_EVICT: if (out_free) state_nxt = ST_SCAN;
      ST_RN_OUTER: state_nxt = rn_commit_r ? ST_RN_WRITE : ST_RN_INNER;
      ST_RN_INNER: if (addr_r == ENTRIES[SLOT_W:0]) state_nxt = ST_RN_WRITE;
      ST_RN_WRITE: begin
        if (rn_i_r == (SLOT_W+1)'(ENTRIES - 1)) begin
          state_nxt = rn_commit_r ? ST_SCAN : ST_RN_OUTER;
        end else begin
          state_nxt = ST_RN_OUTER;
        end
      end
      ST_WRITE: state_nxt = ST_EMIT;
      ST_CLEAR: if (clr_addr_r == SLOT_W'(ENTRIES - 1)) state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath: RAM writes, counters and the result word.
  always_comb begin
    we         = 1'b0;
    waddr      = addr_r[SLOT_W-1:0];
    wrec       = '0;
    ctr_nxt    = ctr_r;
    count_nxt  = count_r;
    todo_nxt   = todo_r;
    insert_nxt = insert_r;
    addr_nxt   = addr_r;
    res_go     = 1'b0;
    res        = '0;
    res.result_key = item_r.key;
    case (state_r)
      ST_IDLE: begin
        addr_nxt   = '0;
        insert_nxt = 1'b0;
      end
      ST_SCAN: addr_nxt = addr_r + 1'b1;
      ST_DECIDE: begin
        addr_nxt = '0;
        case (item_r.command)
          CMD_TRIM: todo_nxt = (count_r > cap) ? count_r - cap : '0;
          CMD_FETCH: begin
            if (!(new_key && ctr_r == STAMP_MAX) && cap != '0) begin
              if (new_key) ctr_nxt = ctr_r + 1'b1;
              insert_nxt = !found_r && item_r.source_has_row;
              // First pass only: size the batch.
              if (!found_r && item_r.source_has_row && !insert_r) begin
                todo_nxt = (count_r >= cap) ? count_r + 1'b1 - base_c : '0;
                if (todo_nxt > count_r) todo_nxt = count_r;
              end
            end
          end
          default: ;
        endcase
      end
      ST_EVICT: begin
        res_go        = 1'b1;
        res.kind      = KIND_EVICT;
        res.result_key = old_key_r;
        res.slot      = 4'(old_slot_r);
        res.occupancy = 5'(count_r - 1'b1);
        if (out_free) begin
          we        = 1'b1;
          waddr     = old_slot_r;
          count_nxt = count_r - 1'b1;
          todo_nxt  = todo_r - 1'b1;
        end
      end
      ST_RN_OUTER: addr_nxt = '0;
      ST_RN_INNER: addr_nxt = addr_r + 1'b1;
      ST_RN_WRITE: begin
        addr_nxt = '0;
        if (rn_commit_r) begin
          // Entry i was read during the outer step; rewrite its stamp.
          we    = rrec.valid;
          waddr = rn_i_r[SLOT_W-1:0];
          wrec  = rrec;
          wrec.stamp = {{(STAMP_BITS-CNT_W){1'b0}}, rank_r[rn_i_r[SLOT_W-1:0]]};
          if (rn_i_r == (SLOT_W+1)'(ENTRIES - 1)) ctr_nxt = rn_live_r;
        end
      end
      ST_WRITE: begin
        if (item_r.command == CMD_REMOVE) begin
          if (found_r) begin
            we = 1'b1; waddr = found_slot_r; count_nxt = count_r - 1'b1;
          end
        end else if (found_r) begin
          we = 1'b1; waddr = found_slot_r;
          wrec = '{valid: 1'b1, key: item_r.key, stamp: ctr_r};
        end else if (item_r.source_has_row && free_ok_r) begin
          we = 1'b1; waddr = free_slot_r;
          wrec = '{valid: 1'b1, key: item_r.key, stamp: ctr_r};
          count_nxt = count_r + 1'b1;
        end
      end
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_addr_r; count_nxt = '0; ctr_nxt = '0;
      end
      ST_EMIT: begin
        res_go        = 1'b1;
        res.last      = 1'b1;
        res.occupancy = 5'(count_r);
        case (item_r.command)
          CMD_CLEAR: begin res.kind = KIND_DONE; res.result_key = '0; end
          CMD_TRIM:  begin res.kind = KIND_DONE; res.result_key = '0; end
          CMD_REMOVE: begin
            res.kind = KIND_DONE;
            res.slot = found_r ? 4'(found_slot_r) : 4'd0;
          end
          default: begin
            if (cap == '0) res.kind = KIND_BYPASS;
            else if (found_r) begin res.kind = KIND_HIT; res.slot = 4'(found_slot_r); end
            else if (item_r.source_has_row && free_ok_r) begin
              res.kind = KIND_INSERT; res.slot = 4'(free_slot_r);
            end else res.kind = KIND_MISS;
          end
        endcase
      end
      default: ;
    endcase
    // The sweep after reset writes zeros through the same port.
    if (!clr_done_r) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wrec  = '0;
    end
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      base_r     <= '0;
      over_r     <= '0;
      ctr_r      <= '0;
      prev_r     <= '1;
      count_r    <= '0;
      todo_r     <= '0;
      insert_r   <= 1'b0;
      addr_r     <= '0;
      out_valid  <= 1'b0;
      clr_done_r <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ctr_r    <= ctr_nxt;
      count_r  <= count_nxt;
      todo_r   <= todo_nxt;
      insert_r <= insert_nxt;
      addr_r   <= addr_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) base_r <= cfg_data;
        if (cfg_index == CFG_OVER) over_r <= cfg_data;
      end
      if (state_r == ST_DECIDE && item_r.command == CMD_FETCH && cap != '0 &&
          !(new_key && ctr_r == STAMP_MAX)) begin
        prev_r <= {1'b0, item_r.key};
      end
      if (out_free) out_valid <= res_go;
      // Post-reset sweep and clear command share the address counter.
      if (!clr_done_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == SLOT_W'(ENTRIES - 1)) clr_done_r <= 1'b1;
      end else if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end else begin
        clr_addr_r <= '0;
      end
    end
  end

  // Payload and scan registers; no reset needed.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && clr_done_r) item_r <= in_data;
    if (out_free && res_go) out_data <= res;
    rslot_r <= addr_r[SLOT_W-1:0];
    // The scan results start over at the beginning of every scan.
    if (state_nxt == ST_SCAN && state_r != ST_SCAN) begin
      found_r <= 1'b0; old_ok_r <= 1'b0; free_ok_r <= 1'b0;
    end else if (scan_rd) begin
      if (rrec.valid && rrec.key == item_r.key) begin
        found_r <= 1'b1; found_slot_r <= rslot_r;
      end
      if (rrec.valid && (!old_ok_r ||
          is_older(rrec.stamp, rslot_r, old_stamp_r, old_slot_r))) begin
        old_ok_r <= 1'b1; old_slot_r <= rslot_r;
        old_stamp_r <= rrec.stamp; old_key_r <= rrec.key;
      end
      if (!rrec.valid && !free_ok_r) begin
        free_ok_r <= 1'b1; free_slot_r <= rslot_r;
      end
    end
    // Renumbering: rank of entry i among live entries.
    if (state_r == ST_RN_OUTER) begin
      rn_rank_r <= '0;
      if (rn_i_r == '0 && !rn_commit_r) rn_live_r <= '0;
    end
    if (state_r == ST_RN_INNER && addr_r == '0) begin
      rn_rec_r <= rrec;  // entry i read during the outer step
      if (rrec.valid) rn_live_r <= rn_live_r + 1'b1;
    end
    if (state_r == ST_RN_INNER && addr_r != '0 && rrec.valid && rn_rec_r.valid &&
        is_older(rrec.stamp, rslot_r, rn_rec_r.stamp, rn_i_r[SLOT_W-1:0])) begin
      rn_rank_r <= rn_rank_r + 1'b1;
    end
    if (state_r == ST_RN_WRITE && !rn_commit_r) begin
      rank_r[rn_i_r[SLOT_W-1:0]] <= CNT_W'(rn_rank_r + 1'b1);
    end
    if (state_r == ST_DECIDE) begin
      rn_i_r      <= '0;
      rn_commit_r <= 1'b0;
    end else if (state_r == ST_RN_WRITE) begin
      if (rn_i_r == (SLOT_W+1)'(ENTRIES - 1)) begin
        rn_i_r      <= '0;
        rn_commit_r <= 1'b1;
      end else begin
        rn_i_r <= rn_i_r + 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("occupancy above table size");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input accepted while busy");
  a_evict_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVICT) |-> old_ok_r)
    else $error("eviction without a valid victim");

endmodule

### sv/lcbe_ram.sv
// ----------------------------------------------------------------------------
// lcbe_ram: generic single-port-write, one-read synchronous RAM
// Registered read: data appears in the cycle after the address.
// ----------------------------------------------------------------------------
module lcbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LRU key directory with batch eviction
// Drives commands through the valid/stall input channel, predicts results
// with a behavioral copy of the directory or takes them from typed rows,
// and checks them in order under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
  import lcbe_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  lru_cache_batch_eviction DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // About 460 commands; even a full batch eviction per command under heavy
  // stalls stays well below this.
  localparam int CYCLE_LIMIT = 500_000;
  localparam int SETTLE      = 60;

  // Behavioral copy of the directory.
  logic                  dir_valid [ENTRIES];
  logic [KEY_W-1:0]      dir_key   [ENTRIES];
  logic [STAMP_BITS-1:0] dir_stamp [ENTRIES];
  logic [STAMP_BITS-1:0] stamp_ctr;
  logic [31:0]           prev_fetch;
  int unsigned           occ;
  int unsigned           base_r, over_r;

  out_item_t pending_results[$];
  int        errors;
  int        cycles;
  bit        quiet_in, quiet_out;

  // Directed stimulus. When typed is set the row's single result is the
  // one written here; otherwise the predictor supplies it.
  typedef struct {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic             row;
    bit               typed;
    out_item_t        want;
  } drow_t;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic int unsigned capacity();
    int unsigned c;
    c = base_r + over_r;
    return (c > ENTRIES) ? ENTRIES : c;
  endfunction

  // Strict age order: lower stamp first, lower slot on equal stamps.
  function automatic bit ages_before(int a, int b);
    return (dir_stamp[a] < dir_stamp[b]) ||
           ((dir_stamp[a] == dir_stamp[b]) && (a < b));
  endfunction

  function automatic int oldest_slot();
    int pick;
    pick = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (dir_valid[i] && (pick < 0 || ages_before(i, pick))) pick = i;
    return pick;
  endfunction

  function automatic int slot_of(logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (dir_valid[i] && dir_key[i] == k) return i;
    return -1;
  endfunction

  function automatic out_item_t make_result(kind_t kd, logic [KEY_W-1:0] k,
                                            int s, bit lst);
    out_item_t r;
    r.kind       = kd;
    r.result_key = k;
    r.slot       = s[3:0];
    r.occupancy  = occ[4:0];
    r.last       = lst;
    return r;
  endfunction

  function automatic void evict_oldest(int unsigned count, ref out_item_t res[$]);
    int s;
    for (int unsigned n = 0; n < count; n++) begin
      s = oldest_slot();
      if (s < 0) return;
      dir_valid[s] = 1'b0;
      occ--;
      res.push_back(make_result(KIND_EVICT, dir_key[s], s, 1'b0));
    end
  endfunction

  // Stamps renumbered 1..n in age order when the counter saturates.
  function automatic void renumber_stamps();
    logic [STAMP_BITS-1:0] rank [ENTRIES];
    int unsigned live;
    live = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      rank[i] = '0;
      if (dir_valid[i]) begin
        live++;
        for (int j = 0; j < ENTRIES; j++)
          if (dir_valid[j] && ages_before(j, i)) rank[i]++;
      end
    end
    for (int i = 0; i < ENTRIES; i++)
      if (dir_valid[i]) dir_stamp[i] = rank[i] + 1'b1;
    stamp_ctr = live[STAMP_BITS-1:0];
  endfunction

  // Works out the results of one accepted command and updates the copy.
  function automatic void predict_directory(in_item_t it, ref out_item_t res[$]);
    int s, f;
    int unsigned cap, b, excess;
    cap = capacity();
    case (cmd_t'(it.command))
      CMD_REMOVE: begin
        s = slot_of(it.key);
        if (s >= 0) begin
          dir_valid[s] = 1'b0;
          occ--;
        end
        res.push_back(make_result(KIND_DONE, it.key, (s >= 0) ? s : 0, 1'b1));
      end
      CMD_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) dir_valid[i] = 1'b0;
        occ = 0;
        stamp_ctr = '0;
        res.push_back(make_result(KIND_DONE, '0, 0, 1'b1));
      end
      CMD_TRIM: begin
        if (occ > cap) evict_oldest(occ - cap, res);
        res.push_back(make_result(KIND_DONE, '0, 0, 1'b1));
      end
      default: begin
        if (cap == 0) begin
          res.push_back(make_result(KIND_BYPASS, it.key, 0, 1'b1));
          return;
        end
        if (prev_fetch != {1'b0, it.key}) begin
          if (stamp_ctr == STAMP_MAX) renumber_stamps();
          stamp_ctr = stamp_ctr + 1'b1;
          prev_fetch = {1'b0, it.key};
        end
        s = slot_of(it.key);
        if (s >= 0) begin
          dir_stamp[s] = stamp_ctr;
          res.push_back(make_result(KIND_HIT, it.key, s, 1'b1));
          return;
        end
        if (!it.source_has_row) begin
          res.push_back(make_result(KIND_MISS, it.key, 0, 1'b1));
          return;
        end
        if (occ >= cap) begin
          b = (base_r < cap) ? base_r : cap;
          excess = occ + 1 - b;
          if (excess > occ) excess = occ;
          evict_oldest(excess, res);
        end
        f = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!dir_valid[i]) f = i;
        if (f < 0) begin
          res.push_back(make_result(KIND_MISS, it.key, 0, 1'b1));
          return;
        end
        dir_valid[f] = 1'b1;
        dir_key[f]   = it.key;
        dir_stamp[f] = stamp_ctr;
        occ++;
        res.push_back(make_result(KIND_INSERT, it.key, f, 1'b1));
      end
    endcase
  endfunction

  // Result checker; stalls are redrawn every cycle.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result kind=%0d key=%h slot=%0d occ=%0d last=%0d",
                   $time, out_data.kind, out_data.result_key, out_data.slot,
                   out_data.occupancy, out_data.last);
        end else begin
          want = pending_results.pop_front();
          if (out_data.kind !== want.kind || out_data.result_key !== want.result_key ||
              out_data.slot !== want.slot || out_data.occupancy !== want.occupancy ||
              out_data.last !== want.last) begin
            errors <= errors + 1;
            $display("%0t: mismatch expected kind=%0d key=%h slot=%0d occ=%0d last=%0d",
                     $time, want.kind, want.result_key, want.slot, want.occupancy,
                     want.last);
            $display("%0t:          actual   kind=%0d key=%h slot=%0d occ=%0d last=%0d",
                     $time, out_data.kind, out_data.result_key, out_data.slot,
                     out_data.occupancy, out_data.last);
          end
        end
      end
      out_stall <= quiet_out ? 1'b0 : ($urandom_range(99) < 14);
    end
  end

  // Presents one command and holds it until the transfer happens. in_valid
  // stays high across back-to-back commands; a gap lowers it first.
  task automatic send_command(in_item_t it, bit typed, out_item_t want);
    out_item_t res[$];
    if (!quiet_in && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_directory(it, res);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (res[i]) pending_results.push_back(res[i]);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sizes(int unsigned b, int unsigned o);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_data  <= b[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_OVER;
    cfg_data  <= o[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    base_r = b & 31;
    over_r = o & 31;
  endtask

  function automatic in_item_t item_of(cmd_t c, logic [KEY_W-1:0] k, logic r);
    in_item_t it;
    it.command        = c;
    it.key            = k;
    it.source_has_row = r;
    return it;
  endfunction

  function automatic out_item_t typed_result(kind_t kd, logic [KEY_W-1:0] k, int o);
    out_item_t r;
    r.kind = kd; r.result_key = k; r.slot = '0; r.occupancy = o[4:0]; r.last = 1'b1;
    return r;
  endfunction

  // Random command: mostly fetches over a small key pool so that hits and
  // evictions are common, now and then a wide random key.
  function automatic in_item_t random_command();
    int unsigned p;
    logic [KEY_W-1:0] k;
    p = $urandom_range(99);
    k = ($urandom_range(9) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(23));
    if (p < 72) return item_of(CMD_FETCH, k, $urandom_range(99) < 85);
    if (p < 86) return item_of(CMD_REMOVE, k, 1'($urandom_range(1)));
    if (p < 89) return item_of(CMD_CLEAR, KEY_W'($urandom), 1'($urandom_range(1)));
    return item_of(CMD_TRIM, KEY_W'($urandom), 1'($urandom_range(1)));
  endfunction

  initial begin
    drow_t     pre_cfg [3];
    drow_t     plan [$];
    out_item_t none;
    int unsigned sizes [8][2];

    errors    = 0;
    cycles    = 0;
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    none      = '0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BASE;
    cfg_data  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      dir_valid[i] = 1'b0; dir_key[i] = '0; dir_stamp[i] = '0;
    end
    stamp_ctr  = '0;
    prev_fetch = '1;
    occ        = 0;
    base_r     = 0;
    over_r     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero capacity after reset: fetches bypass, clear reports done.
    pre_cfg[0] = '{CMD_FETCH, 31'h7FFF_FFFF, 1'b1, 1'b1,
                   typed_result(KIND_BYPASS, 31'h7FFF_FFFF, 0)};
    pre_cfg[1] = '{CMD_FETCH, 31'h0, 1'b0, 1'b1, typed_result(KIND_BYPASS, 31'h0, 0)};
    pre_cfg[2] = '{CMD_CLEAR, 31'h5555_5555, 1'b1, 1'b1, typed_result(KIND_DONE, 31'h0, 0)};
    foreach (pre_cfg[i])
      send_command(item_of(pre_cfg[i].cmd, pre_cfg[i].key, pre_cfg[i].row),
                   pre_cfg[i].typed, pre_cfg[i].want);
    wait_drained();

    // Capacity three, base two: fill, miss without a row, hit, batch
    // eviction, removal present and absent, trim that has nothing to do.
    write_sizes(2, 1);
    plan.push_back('{CMD_FETCH, 31'h0, 1'b1, 1'b0, none});
    plan.push_back('{CMD_FETCH, 31'h7FFF_FFFF, 1'b1, 1'b0, none});
    plan.push_back('{CMD_FETCH, 31'h5, 1'b0, 1'b1, typed_result(KIND_MISS, 31'h5, 2)});
    plan.push_back('{CMD_FETCH, 31'h0, 1'b1, 1'b0, none});
    plan.push_back('{CMD_FETCH, 31'h0, 1'b1, 1'b0, none});
    plan.push_back('{CMD_FETCH, 31'h2AAA_AAAA, 1'b1, 1'b0, none});
    plan.push_back('{CMD_FETCH, 31'h1, 1'b1, 1'b0, none});
    plan.push_back('{CMD_FETCH, 31'h2, 1'b1, 1'b0, none});
    plan.push_back('{CMD_REMOVE, 31'h2, 1'b0, 1'b0, none});
    plan.push_back('{CMD_REMOVE, 31'h1234, 1'b1, 1'b0, none});
    plan.push_back('{CMD_TRIM, 31'h0, 1'b0, 1'b0, none});
    plan.push_back('{CMD_FETCH, 31'h3, 1'b1, 1'b0, none});
    plan.push_back('{CMD_FETCH, 31'h4, 1'b1, 1'b0, none});
    foreach (plan[i])
      send_command(item_of(plan[i].cmd, plan[i].key, plan[i].row),
                   plan[i].typed, plan[i].want);
    wait_drained();

    // Shrinking the capacity takes effect on the next trim.
    write_sizes(0, 1);
    send_command(item_of(CMD_TRIM, 31'h0, 1'b0), 1'b0, none);
    send_command(item_of(CMD_FETCH, 31'h9, 1'b1), 1'b0, none);
    wait_drained();

    // Random traffic over several size settings, extremes included. The
    // second phase runs without gaps or stalls.
    sizes = '{'{4, 2}, '{16, 16}, '{1, 0}, '{16, 0}, '{0, 0},
              '{3, 15}, '{8, 4}, '{0, 16}};
    for (int ph = 0; ph < 8; ph++) begin
      write_sizes(sizes[ph][0], sizes[ph][1]);
      quiet_in  = (ph == 1);
      quiet_out = (ph == 1);
      for (int n = 0; n < 55; n++) send_command(random_command(), 1'b0, none);
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
